// ----- sv/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/twqa_pkg.sv -----
package twqa_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 16;

    localparam int LIMIT_W  = 4;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

    // item kinds on the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ_NORMAL = 2'd0,
        KIND_ENQ_PRIO   = 2'd1,
        KIND_SERVICE    = 2'd2
    } t_kind;

    // result codes on the output tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_PRIORITY = 2'd0,
        ST_NORMAL   = 2'd1,
        ST_WAIT     = 2'd2,
        ST_REJECT   = 2'd3
    } t_status;

    // queue command from the arbiter
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    // queue occupancy flags back to the arbiter
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- sv/twqa_ram.sv -----
module twqa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/twqa_queue.sv -----
module twqa_queue #(
    parameter int DEPTH    = twqa_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH = twqa_pkg::ID_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  twqa_pkg::t_q_ctrl   i_ctrl,
    input  logic [ID_WIDTH-1:0] i_push_id,
    output twqa_pkg::t_q_status o_status,
    output logic [ID_WIDTH-1:0] o_head_id
);

    import twqa_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    // wrap for depths that are not a power of two
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_head  = i_ctrl.pop  ? ptr_inc(r_head) : r_head;
        n_tail  = i_ctrl.push ? ptr_inc(r_tail) : r_tail;
        n_count = r_count;
        if (i_ctrl.push && !i_ctrl.pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctrl.pop && !i_ctrl.push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    // head entry is read on pop and held until the next pop
    twqa_ram #(
        .WIDTH(ID_WIDTH),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_ctrl.push),
        .i_wr_addr(r_tail),
        .i_wr_data(i_push_id),
        .i_rd_en  (i_ctrl.pop),
        .i_rd_addr(r_head),
        .o_rd_data(o_head_id)
    );

endmodule

// ----- sv/two_queue_weighted_priority_arbiter.sv -----
// a result shows on the master side in the cycle after its item is accepted
// throughput: one item per cycle, held back only while a result waits on i_m_tready
// latency set by the single result register, each queue store read in that same cycle
// reset (i_rst_n low, synchronous): both queues empty, streak cleared, burst limit 3
// queue stores are not cleared; only entries written since reset are ever read
module two_queue_weighted_priority_arbiter #(
    parameter int QUEUE_DEPTH = twqa_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = twqa_pkg::ID_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave side
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [((ID_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata,  // ticket_id
    input  logic [twqa_pkg::KIND_W-1:0]           i_s_tuser,  // kind
    // master side
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [((ID_WIDTH + 7) / 8) * 8 - 1:0] o_m_tdata,  // served_id
    output logic [twqa_pkg::STATUS_W-1:0]         o_m_tuser,  // status
    // burst limit register write
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [twqa_pkg::LIMIT_W-1:0]          i_cfg_data
);

    import twqa_pkg::*;

    `include "assert_macros.svh"

    localparam int DATA_W = ((ID_WIDTH + 7) / 8) * 8;

    // configuration and arbitration state
    logic [LIMIT_W-1:0] r_burst_limit;
    logic [LIMIT_W-1:0] r_streak, n_streak;

    // result register; a served id of a service comes from the queue read register
    logic                r_out_valid, n_out_valid;
    t_status             r_status, n_status;
    logic [ID_WIDTH-1:0] r_reject_id, n_reject_id;

    logic                accept;
    t_kind               kind;
    logic [ID_WIDTH-1:0] in_id;
    logic                has_result;
    logic                normal_first;
    logic                take_normal;
    t_q_ctrl             prio_ctrl, norm_ctrl;
    t_q_status           prio_stat, norm_stat;
    logic [ID_WIDTH-1:0] prio_head, norm_head;
    logic [ID_WIDTH-1:0] served_id;

    // the register port never stalls
    assign o_cfg_ready = 1'b1;

    // the next item goes in when the result slot is free or being emptied
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign kind       = t_kind'(i_s_tuser);
    assign in_id      = i_s_tdata[ID_WIDTH-1:0];

    // streak at or past the limit hands the turn to a waiting normal ticket
    assign normal_first = (r_streak >= r_burst_limit);
    assign take_normal  = normal_first ? !norm_stat.empty : prio_stat.empty;

    always_comb begin
        prio_ctrl   = '0;
        norm_ctrl   = '0;
        has_result  = 1'b0;
        n_status    = r_status;
        n_reject_id = r_reject_id;
        n_streak    = r_streak;
        if (accept) begin
            case (kind)
                KIND_ENQ_NORMAL: begin
                    if (norm_stat.full) begin
                        has_result  = 1'b1;
                        n_status    = ST_REJECT;
                        n_reject_id = in_id;
                    end else begin
                        norm_ctrl.push = 1'b1;
                    end
                end
                KIND_ENQ_PRIO: begin
                    if (prio_stat.full) begin
                        has_result  = 1'b1;
                        n_status    = ST_REJECT;
                        n_reject_id = in_id;
                    end else begin
                        prio_ctrl.push = 1'b1;
                    end
                end
                KIND_SERVICE: begin
                    has_result = 1'b1;
                    if (prio_stat.empty && norm_stat.empty) begin
                        n_status = ST_WAIT;
                    end else if (take_normal) begin
                        norm_ctrl.pop = 1'b1;
                        n_status      = ST_NORMAL;
                        n_streak      = '0;
                    end else begin
                        prio_ctrl.pop = 1'b1;
                        n_status      = ST_PRIORITY;
                        // saturate so normal tickets are never starved
                        n_streak      = (r_streak < r_burst_limit) ?
                                        r_streak + LIMIT_W'(1) : r_burst_limit;
                    end
                end
                default: begin
                    // unused kind code: dropped quietly
                end
            endcase
        end
        n_out_valid = accept ? has_result : (r_out_valid && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_limit <= LIMIT_RESET;
            r_streak      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_burst_limit <= i_cfg_data;
            end
            r_streak    <= n_streak;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_reject_id <= n_reject_id;
    end

    twqa_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .ID_WIDTH(ID_WIDTH)
    ) u_prio_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (prio_ctrl),
        .i_push_id(in_id),
        .o_status (prio_stat),
        .o_head_id(prio_head)
    );

    twqa_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .ID_WIDTH(ID_WIDTH)
    ) u_norm_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (norm_ctrl),
        .i_push_id(in_id),
        .o_status (norm_stat),
        .o_head_id(norm_head)
    );

    // served id picked by the registered status
    always_comb begin
        case (r_status)
            ST_PRIORITY: served_id = prio_head;
            ST_NORMAL:   served_id = norm_head;
            ST_REJECT:   served_id = r_reject_id;
            default:     served_id = '0;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = DATA_W'(served_id);

    // a queue is never popped while empty nor pushed while full
    `ASSERT_SAME(a_no_bad_pop, i_clk, i_rst_n, prio_ctrl.pop || norm_ctrl.pop, !(prio_ctrl.pop ? prio_stat.empty : norm_stat.empty))
    `ASSERT_SAME(a_no_bad_push, i_clk, i_rst_n, prio_ctrl.push || norm_ctrl.push, !(prio_ctrl.push ? prio_stat.full : norm_stat.full))
    // a priority service leaves the streak within the limit
    `ASSERT_NEXT(a_streak_sat, i_clk, i_rst_n, prio_ctrl.pop && !i_cfg_valid, r_streak <= r_burst_limit)
    // a normal service clears the streak
    `ASSERT_NEXT(a_streak_clr, i_clk, i_rst_n, norm_ctrl.pop, r_streak == '0)

endmodule

// ----- tb/two_queue_weighted_priority_arbiter_test.sv -----
module two_queue_weighted_priority_arbiter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import twqa_pkg::*;

    localparam int DEPTH    = QUEUE_DEPTH_DEF;
    localparam int ID_W     = ID_WIDTH_DEF;
    localparam int DATA_W   = ((ID_W + 7) / 8) * 8;

    // kind code the block must ignore without a result
    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = '1;

    // receiver hold-off long enough to fill the result register and stall the input
    localparam int LONG_STALL   = 80;
    // cycles allowed after the last result before touching the limit register
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        t_status          status;
        logic [ID_W-1:0]  ticket;
    } outcome_t;

    // dut ports, all inputs driven to known values from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [DATA_W-1:0]    i_s_tdata   = '0;   // ticket_id
    logic [KIND_W-1:0]    i_s_tuser   = '0;   // kind
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [DATA_W-1:0]    o_m_tdata;          // served_id
    logic [STATUS_W-1:0]  o_m_tuser;          // status
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [LIMIT_W-1:0]   i_cfg_data  = '0;

    // predictor state: both ticket queues, the priority streak and the limit
    logic [ID_W-1:0]      prio_tickets[$];
    logic [ID_W-1:0]      normal_tickets[$];
    logic [LIMIT_W-1:0]   prio_streak = '0;
    logic [LIMIT_W-1:0]   burst_limit = LIMIT_RESET;

    // results still owed by the block, oldest first
    outcome_t             pending_outcomes[$];
    int                   error_count = 0;

    // idling control: steady flags switch random idling off on either side
    logic                 tx_steady = 1'b0;
    logic                 rx_steady = 1'b0;
    int                   hold_requests = 0;
    int                   holds_granted = 0;
    int                   stall_left = 0;

    two_queue_weighted_priority_arbiter #(
        .QUEUE_DEPTH (DEPTH),
        .ID_WIDTH    (ID_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected arbitration for one accepted item; enqueues that fit owe nothing
    function automatic void arbitrate_ticket(input logic [KIND_W-1:0] kind,
                                             input logic [ID_W-1:0] ticket);
        outcome_t outcome;
        logic     take_normal;
        outcome.ticket = '0;
        if (kind == KIND_ENQ_NORMAL || kind == KIND_ENQ_PRIO) begin
            if (kind == KIND_ENQ_PRIO && prio_tickets.size() < DEPTH) begin
                prio_tickets.push_back(ticket);
                return;
            end
            if (kind == KIND_ENQ_NORMAL && normal_tickets.size() < DEPTH) begin
                normal_tickets.push_back(ticket);
                return;
            end
            // full queue: ticket dropped and handed back
            outcome.status = ST_REJECT;
            outcome.ticket = ticket;
        end else if (kind == KIND_SERVICE) begin
            if (prio_tickets.size() == 0 && normal_tickets.size() == 0) begin
                // nothing waiting, streak left alone
                outcome.status = ST_WAIT;
            end else begin
                // streak reached (also when the limit dropped below it): normal goes first
                if (prio_streak >= burst_limit)
                    take_normal = (normal_tickets.size() != 0);
                else
                    take_normal = (prio_tickets.size() == 0);
                if (take_normal) begin
                    outcome.status = ST_NORMAL;
                    outcome.ticket = normal_tickets.pop_front();
                    prio_streak    = '0;
                end else begin
                    outcome.status = ST_PRIORITY;
                    outcome.ticket = prio_tickets.pop_front();
                    // saturate at the limit so normal tickets never starve
                    prio_streak    = (prio_streak < burst_limit) ? prio_streak + 1'b1
                                                                 : burst_limit;
                end
            end
        end else begin
            return;
        end
        pending_outcomes.push_back(outcome);
    endfunction

    function automatic logic [ID_W-1:0] random_ticket();
        case ($urandom_range(19))
            0: return '0;
            1: return '1;
            default: return ID_W'($urandom);
        endcase
    endfunction

    // receiver: random idling, steady stretches and one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_requests != holds_granted) begin
            holds_granted <= hold_requests;
            stall_left    <= LONG_STALL;
            i_m_tready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            i_m_tready    <= 1'b0;
        end else if (rx_steady) begin
            i_m_tready    <= 1'b1;
        end else begin
            i_m_tready    <= ($urandom_range(99) >= 14);
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        outcome_t want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result: status %0d served_id %0h", o_m_tuser, o_m_tdata);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_m_tuser !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_m_tuser);
                    error_count++;
                end
                if (o_m_tdata !== DATA_W'(want.ticket)) begin
                    $error("served_id expected %0h actual %0h", want.ticket, o_m_tdata);
                    error_count++;
                end
            end
        end
    end

    // offer one item, with an occasional gap first; valid stays high between items
    task automatic offer_ticket_item(input logic [KIND_W-1:0] kind,
                                     input logic [ID_W-1:0] ticket);
        if (!tx_steady && $urandom_range(99) < 14) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= DATA_W'(ticket);
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        arbitrate_ticket(kind, ticket);
    endtask

    // stop offering, collect every owed result, then let enqueues settle
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_burst_limit(input logic [LIMIT_W-1:0] limit);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        burst_limit = limit;
    endtask

    // random kinds with a given share of service requests; ignored kinds not counted
    task automatic run_random_phase(input int count, input int service_pct);
        int                sent;
        int                pick;
        logic [KIND_W-1:0] kind;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 3)
                kind = KIND_UNUSED;
            else if (pick < 3 + service_pct)
                kind = KIND_SERVICE;
            else
                kind = $urandom_range(1) ? KIND_ENQ_PRIO : KIND_ENQ_NORMAL;
            offer_ticket_item(kind, random_ticket());
            if (kind != KIND_UNUSED)
                sent++;
        end
    endtask

    // service on empty queues and the unused kind
    task automatic test_wait_and_unused();
        offer_ticket_item(KIND_SERVICE, 16'h1234);
        offer_ticket_item(KIND_UNUSED,  16'hFFFF);
        offer_ticket_item(KIND_SERVICE, 16'hFFFF);
    endtask

    // id extremes through both queues, streak reaching a limit of two
    task automatic test_streak_and_extremes();
        write_burst_limit(4'd2);
        offer_ticket_item(KIND_ENQ_PRIO,   16'hFFFF);
        offer_ticket_item(KIND_ENQ_PRIO,   16'h0000);
        offer_ticket_item(KIND_ENQ_PRIO,   16'hA5A5);
        offer_ticket_item(KIND_ENQ_NORMAL, 16'hFFFF);
        offer_ticket_item(KIND_ENQ_NORMAL, 16'h0000);
        // priority, priority, normal after streak, priority, normal, then wait
        repeat (6) offer_ticket_item(KIND_SERVICE, random_ticket());
    endtask

    // top limit, limit lowered under the streak with saturation, then limit zero
    task automatic test_limit_changes();
        write_burst_limit(LIMIT_MAX);
        repeat (2) offer_ticket_item(KIND_ENQ_PRIO, random_ticket());
        repeat (2) offer_ticket_item(KIND_SERVICE, random_ticket());
        // streak of two now sits above the new limit
        write_burst_limit(4'd1);
        offer_ticket_item(KIND_ENQ_PRIO, random_ticket());
        // normal queue empty, so priority served and streak clamps to one
        offer_ticket_item(KIND_SERVICE, random_ticket());
        offer_ticket_item(KIND_ENQ_NORMAL, random_ticket());
        offer_ticket_item(KIND_ENQ_PRIO, random_ticket());
        offer_ticket_item(KIND_SERVICE, random_ticket());
        // limit zero: a waiting normal ticket always wins
        write_burst_limit(4'd0);
        offer_ticket_item(KIND_ENQ_NORMAL, random_ticket());
        offer_ticket_item(KIND_ENQ_PRIO, random_ticket());
        repeat (2) offer_ticket_item(KIND_SERVICE, random_ticket());
    endtask

    // long receiver hold-off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        write_burst_limit(4'd4);
        hold_requests <= hold_requests + 1;
        run_random_phase(60, 50);
    endtask

    // phases over several limits; enqueue-heavy ones fill both queues to rejection
    task automatic test_random_traffic();
        logic [LIMIT_W-1:0] limits[8];
        int                 service_pct[8];
        limits      = '{LIMIT_MAX, 4'd1, 4'd0, 4'd7, 4'd2,
                        LIMIT_W'($urandom_range(15)), 4'd3, LIMIT_W'($urandom_range(1, 15))};
        service_pct = '{50, 20, 75, 40, 60, 20, 80, 50};
        for (int phase = 0; phase < 8; phase++) begin
            write_burst_limit(limits[phase]);
            // one phase with no idling on either side
            tx_steady <= (phase == 3);
            rx_steady <= (phase == 3);
            run_random_phase(225, service_pct[phase]);
        end
        tx_steady <= 1'b0;
        rx_steady <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_wait_and_unused();
        test_streak_and_extremes();
        test_limit_changes();
        test_output_backpressure();
        test_random_traffic();
        drain_results();
        if (error_count == 0) begin
            $display("two_queue_weighted_priority_arbiter: match");
        end else begin
            $display("two_queue_weighted_priority_arbiter: mismatch");
        end
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("two_queue_weighted_priority_arbiter: mismatch");
        $finish;
    end

endmodule
